>>> design/swma_pkg.sv
package swma_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_DEL_MID = 2'd2,
      FUNC_QUERY   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type                   func;
      logic signed [WORD_W-1:0]   push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   popped_value;
      logic signed [WORD_W-1:0]   middle_value;
      logic                       middle_valid;
      logic [COUNT_W-1:0]         entry_count;
      status_type                 status;
   } rsp_type;

endpackage

>>> design/swma_exec.sv
module swma_exec #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              exec_en,
   input  swma_pkg::req_type op,
   output swma_pkg::rsp_type result
);
   import swma_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic signed [WORD_W-1:0] entries_ff [DEPTH];
   logic signed [WORD_W-1:0] entries_in [DEPTH];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [CW-1:0]            mid_old;
   logic [CW-1:0]            top_pos;
   logic [CW-1:0]            mid_new;
   logic                     empty;
   logic                     full;
   logic                     do_push;
   logic                     do_pop;
   logic                     do_del;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_COUNT);
   assign mid_old = count_ff >> 1;
   assign top_pos = count_ff - CW'(1);

   assign do_push = (op.func == FUNC_PUSH)    && !full;
   assign do_pop  = (op.func == FUNC_POP)     && !empty;
   assign do_del  = (op.func == FUNC_DEL_MID) && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop || do_del) begin
         count_in = top_pos;
      end
   end

   // per-lane next value: push writes the slot at count, delete pulls the upper part down
   for (genvar i = 0; i < DEPTH; i++) begin : g_lane
      always_comb begin
         entries_in[i] = entries_ff[i];
         if (do_push && (count_ff == CW'(i))) begin
            entries_in[i] = op.push_value;
         end
         if (i + 1 < DEPTH) begin
            if (do_del && (CW'(i) >= mid_old) && (CW'(i + 1) < count_ff)) begin
               entries_in[i] = entries_ff[(i + 1) % DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (exec_en) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign mid_new = count_in >> 1;

   always_comb begin
      result              = '0;
      result.entry_count  = COUNT_W'(count_in);
      result.middle_valid = (count_in != '0);
      if (count_in != '0) begin
         result.middle_value = entries_in[mid_new[IW-1:0]];
      end
      if (do_pop) begin
         result.popped_value = entries_ff[top_pos[IW-1:0]];
      end
      case (op.func)
         FUNC_PUSH:    result.status = full  ? STATUS_FULL  : STATUS_OK;
         FUNC_POP:     result.status = empty ? STATUS_EMPTY : STATUS_OK;
         FUNC_DEL_MID: result.status = empty ? STATUS_EMPTY : STATUS_OK;
         default:      result.status = STATUS_OK;
      endcase
   end

endmodule

>>> design/stack_with_middle_access.sv
// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_ready  swma_pkg::req_type (func, push_value)
// rsp_*     out        rsp_valid / rsp_ready  swma_pkg::rsp_type (popped, middle, count, status)
//
// One transfer per cycle sustained while rsp_ready stays high; a request passes the stage 1
// register and then the stage 2 register before rsp_valid rises with its response.
// Stage 1 registers the request, stage 2 executes it against the stack and registers the result.
// Stack state changes only when stage 1 moves into stage 2, so operations apply in order.
// A stalled rsp holds stage 2, then stage 1; req_ready drops only when both are full.
// Synchronous active-high reset empties the stack and both stages; entry data is not cleared.
module stack_with_middle_access #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swma_pkg::rsp_type rsp_data
);
   import swma_pkg::*;

   req_type req_ff;
   logic    in_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    out_valid_ff;
   logic    advance;

   // execute when stage 1 holds an op and stage 2 is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   swma_exec #(
      .DEPTH (DEPTH)
   ) u_exec (
      .clock   (clock),
      .reset   (reset),
      .exec_en (advance),
      .op      (req_ff),
      .result  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("executed op did not reach the result stage");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(req_ff)))
      else $error("stalled request lost or changed");

   a_full_no_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL)
         |-> (rsp_data.popped_value == '0 && rsp_data.middle_valid))
      else $error("full status with inconsistent result");

   a_empty_mid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.middle_valid) |-> (rsp_data.middle_value == '0))
      else $error("middle value nonzero on empty stack");

endmodule
